### rtl/mhtp_pkg.sv
// Shared types and constants for the timed stepper positioner.
package mhtp_pkg;

  localparam int unsigned TRAVEL_W = 20;
  localparam int unsigned ANGLE_W  = 17;
  localparam int unsigned POS_W    = 21;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PROD_W   = TRAVEL_W + ANGLE_W;
  localparam int unsigned IN_W     = 24;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned CFG_AW   = 4;
  localparam int unsigned CFG_DW   = 32;

  localparam logic [POS_W-1:0] POS_MAX   = 21'h1F_FFFF;
  localparam logic [3:0]       LOW_LIMIT = 4'd10;
  localparam logic [3:0]       LOW_SAT   = 4'd15;
  localparam logic [POS_W-1:0] NEAR_MS   = 21'd20;
  localparam logic [5:0]       DIV_LAST  = 6'(PROD_W - 1);

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_TRAVEL = 2'd0;
  localparam logic [1:0] REG_ANG_LO = 2'd1;
  localparam logic [1:0] REG_ANG_HI = 2'd2;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_CALIB = 2'd1,
    ACT_ANGLE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STS_MOVING = 2'd0,
    STS_THERE  = 2'd1,
    STS_REJECT = 2'd2,
    STS_FAULT  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_CNT,
    ST_TICK_OVER,
    ST_TICK_DONE,
    ST_CALIB,
    ST_MV_CHECK,
    ST_MV_MUL,
    ST_MV_DIV,
    ST_MV_DIFF,
    ST_MV_APPLY,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic accept;
    logic tick_cnt;
    logic tick_over;
    logic tick_done;
    logic calib;
    logic mv_check;
    logic mv_mul;
    logic div_step;
    logic mv_diff;
    logic mv_apply;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic over_pending;
    logic move_ok;
    logic div_last;
  } sts_t;

endpackage

### rtl/mhtp_ctrl.sv
// Sequencer: steps one beat at a time through tick, calibrate or move handling.
module mhtp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  mhtp_pkg::sts_t     sts,
  output mhtp_pkg::cmd_t     cmd
);
  import mhtp_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            ACT_TICK:  state_nxt = ST_TICK_CNT;
            ACT_CALIB: state_nxt = ST_CALIB;
            ACT_ANGLE: state_nxt = ST_MV_CHECK;
            default:   state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_TICK_CNT:  state_nxt = sts.over_pending ? ST_TICK_OVER : ST_RESULT;
      ST_TICK_OVER: state_nxt = ST_TICK_DONE;
      ST_TICK_DONE: state_nxt = ST_RESULT;
      ST_CALIB:     state_nxt = ST_RESULT;
      ST_MV_CHECK:  state_nxt = sts.move_ok ? ST_MV_MUL : ST_RESULT;
      ST_MV_MUL:    state_nxt = ST_MV_DIV;
      ST_MV_DIV:    state_nxt = sts.div_last ? ST_MV_DIFF : ST_MV_DIV;
      ST_MV_DIFF:   state_nxt = ST_MV_APPLY;
      ST_MV_APPLY:  state_nxt = ST_RESULT;
      ST_RESULT:    state_nxt = out_free ? ST_IDLE : ST_RESULT;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:      cmd.accept    = in_tvalid;
      ST_TICK_CNT:  cmd.tick_cnt  = 1'b1;
      ST_TICK_OVER: cmd.tick_over = 1'b1;
      ST_TICK_DONE: cmd.tick_done = 1'b1;
      ST_CALIB:     cmd.calib     = 1'b1;
      ST_MV_CHECK:  cmd.mv_check  = 1'b1;
      ST_MV_MUL:    cmd.mv_mul    = 1'b1;
      ST_MV_DIV:    cmd.div_step  = 1'b1;
      ST_MV_DIFF:   cmd.mv_diff   = 1'b1;
      ST_MV_APPLY:  cmd.mv_apply  = 1'b1;
      ST_RESULT:    cmd.out_load  = out_free;
      default:      cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/mhtp_dp.sv
// Datapath: positioner state, angle mapping with serial divider, result register.
module mhtp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mhtp_pkg::cmd_t                cmd,
  output mhtp_pkg::sts_t                sts,
  input  logic [mhtp_pkg::IN_W-1:0]     in_tdata,
  input  logic [mhtp_pkg::TRAVEL_W-1:0] travel_ms,
  input  logic signed [mhtp_pkg::ANGLE_W-1:0] angle_low,
  input  logic signed [mhtp_pkg::ANGLE_W-1:0] angle_high,
  output logic [mhtp_pkg::OUT_W-1:0]    out_tdata
);
  import mhtp_pkg::*;

  // architectural state
  logic              calibrated_r;
  logic              move_done_r;
  logic [3:0]        low_count_r;
  logic [POS_W-1:0]  position_r;
  logic [POS_W-1:0]  target_r;
  logic [TIME_W-1:0] stop_time_r;
  logic [TIME_W-1:0] time_count_r;
  logic              home_level_r;
  logic              motor_run_r;
  logic              dir_reg_r;
  logic [1:0]        status_r;
  logic              cev_r;
  logic              dev_r;

  // per-beat working registers
  logic                      limit_r;
  logic                      hdir_r;
  logic signed [ANGLE_W-1:0] ang_r;
  logic [ANGLE_W-1:0]        span_r;
  logic [ANGLE_W-1:0]        off_r;
  logic [PROD_W-1:0]         dvd_r;
  logic [ANGLE_W-1:0]        rem_r;
  logic [5:0]                div_cnt_r;
  logic [TIME_W-1:0]         over_r;
  logic [POS_W-1:0]          diff_r;
  logic                      up_r;
  logic [OUT_W-1:0]          out_data_r;

  logic [3:0]                low_count_nxt;
  logic                      calib_hit;
  logic signed [ANGLE_W-1:0] amin, amax;
  logic                      fault, reject;
  logic signed [ANGLE_W:0]   span_w, off_w;
  logic [PROD_W-1:0]         prod_w;
  logic [ANGLE_W:0]          shl_w, sub_w;
  logic                      ge_w;
  logic [POS_W-1:0]          quo_w;
  logic                      up_w;
  logic [TIME_W-1:0]         sum_w;
  logic [POS_W-1:0]          pos_sat_w;

  // limit switch debounce
  always_comb begin
    if (limit_r) begin
      low_count_nxt = '0;
    end else if (low_count_r == LOW_SAT) begin
      low_count_nxt = low_count_r;
    end else begin
      low_count_nxt = low_count_r + 4'd1;
    end
  end
  assign calib_hit = (low_count_nxt > LOW_LIMIT);

  // angle limits and checks
  assign amin   = (angle_low < angle_high) ? angle_low : angle_high;
  assign amax   = (angle_low < angle_high) ? angle_high : angle_low;
  assign fault  = (travel_ms == '0) || (angle_low == angle_high);
  assign reject = !calibrated_r || (ang_r > amax) || (ang_r < amin);
  assign span_w = {amax[ANGLE_W-1], amax} - {amin[ANGLE_W-1], amin};
  assign off_w  = {ang_r[ANGLE_W-1], ang_r} - {amin[ANGLE_W-1], amin};

  assign prod_w = {{ANGLE_W{1'b0}}, travel_ms} * {{TRAVEL_W{1'b0}}, off_r};

  // restoring divider, one quotient bit a cycle
  assign shl_w = {rem_r, dvd_r[PROD_W-1]};
  assign ge_w  = (shl_w >= {1'b0, span_r});
  assign sub_w = shl_w - {1'b0, span_r};

  // quotient never exceeds travel_ms, so the low bits hold it
  assign quo_w = dvd_r[POS_W-1:0];
  assign up_w  = (quo_w > position_r);

  // overshoot is below 2^31 here, so the sum cannot wrap
  assign sum_w     = {{(TIME_W-POS_W){1'b0}}, target_r} + over_r;
  assign pos_sat_w = (sum_w > {{(TIME_W-POS_W){1'b0}}, POS_MAX}) ? POS_MAX
                                                                 : sum_w[POS_W-1:0];

  assign sts.over_pending = calibrated_r && !move_done_r;
  assign sts.move_ok      = !fault && !reject;
  assign sts.div_last     = (div_cnt_r == DIV_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calibrated_r <= 1'b0;
      move_done_r  <= 1'b1;
      low_count_r  <= '0;
      position_r   <= '0;
      target_r     <= '0;
      stop_time_r  <= '0;
      time_count_r <= '0;
      home_level_r <= 1'b0;
      motor_run_r  <= 1'b0;
      dir_reg_r    <= 1'b0;
      status_r     <= STS_MOVING;
      cev_r        <= 1'b0;
      dev_r        <= 1'b0;
    end else begin
      if (cmd.accept) begin
        status_r <= STS_MOVING;
        cev_r    <= 1'b0;
        dev_r    <= 1'b0;
      end
      if (cmd.tick_cnt) begin
        time_count_r <= time_count_r + 32'd1;
        if (!calibrated_r) begin
          low_count_r <= low_count_nxt;
          if (calib_hit) begin
            calibrated_r <= 1'b1;
            move_done_r  <= 1'b1;
            position_r   <= '0;
            motor_run_r  <= 1'b0;
            cev_r        <= 1'b1;
          end
        end
      end
      if (cmd.tick_done) begin
        if ((over_r != '0) && !over_r[TIME_W-1]) begin
          motor_run_r <= 1'b0;
          move_done_r <= 1'b1;
          position_r  <= pos_sat_w;
          dev_r       <= 1'b1;
        end
      end
      if (cmd.calib) begin
        home_level_r <= hdir_r;
        dir_reg_r    <= hdir_r;
        motor_run_r  <= 1'b1;
      end
      if (cmd.mv_check) begin
        if (fault) begin
          status_r <= STS_FAULT;
        end else if (reject) begin
          status_r <= STS_REJECT;
        end
      end
      if (cmd.mv_diff) begin
        target_r    <= quo_w;
        move_done_r <= 1'b0;
      end
      if (cmd.mv_apply) begin
        if (diff_r < NEAR_MS) begin
          stop_time_r <= time_count_r;
          motor_run_r <= 1'b0;
          status_r    <= STS_THERE;
        end else begin
          dir_reg_r   <= up_r ? !home_level_r : home_level_r;
          stop_time_r <= time_count_r + {{(TIME_W-POS_W){1'b0}}, diff_r};
          motor_run_r <= 1'b1;
          status_r    <= STS_MOVING;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      limit_r <= in_tdata[0];
      hdir_r  <= in_tdata[1];
      ang_r   <= in_tdata[ANGLE_W+1:2];
    end
    if (cmd.tick_over) begin
      over_r <= time_count_r - stop_time_r;
    end
    if (cmd.mv_check) begin
      span_r <= span_w[ANGLE_W-1:0];
      off_r  <= off_w[ANGLE_W-1:0];
    end
    if (cmd.mv_mul) begin
      dvd_r     <= prod_w;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= ge_w ? sub_w[ANGLE_W-1:0] : shl_w[ANGLE_W-1:0];
      dvd_r     <= {dvd_r[PROD_W-2:0], ge_w};
      div_cnt_r <= div_cnt_r + 6'd1;
    end
    if (cmd.mv_diff) begin
      up_r   <= up_w;
      diff_r <= up_w ? (quo_w - position_r) : (position_r - quo_w);
    end
    if (cmd.out_load) begin
      out_data_r <= {5'd0, position_r, dev_r, cev_r, status_r, dir_reg_r, motor_run_r};
    end
  end

  assign out_tdata = out_data_r;

endmodule

### rtl/motor_homing_timed_positioner_core.sv
// Top level: configuration registers, sequencer and datapath of the positioner.
//
// Timed stepper positioner with limit-switch homing. One input beat gives one
// result beat. A tick passes through the count state (and, while a move is
// running, the overshoot and done states) on its way to the result register, and a
// calibrate start through a single state. A set angle that passes its checks runs
// a single multiply and then a 37-step restoring divider for the angle-to-
// milliseconds mapping, one quotient bit per cycle. A rejected or faulty set angle goes straight to the result.
// The result sits in an output register; the next beat is taken once the
// previous one has reached that register.
// Configuration is an APB-style port with travel_ms at 0x0, angle_low at 0x4 and
// angle_high at 0x8; angle reads come back sign-extended.
module motor_homing_timed_positioner_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [0] limit_level, [1] home_dir, [18:2] target_angle, [23:19] zero
  input  logic [mhtp_pkg::IN_W-1:0]   in_tdata,
  // [1:0] action
  input  logic [1:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [0] motor_on, [1] dir_level, [3:2] status, [4] calib_event,
  // [5] done_event, [26:6] position_ms, [31:27] zero
  output logic [mhtp_pkg::OUT_W-1:0]  out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mhtp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [mhtp_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [mhtp_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import mhtp_pkg::*;

  logic [TRAVEL_W-1:0]       travel_ms_r;
  logic signed [ANGLE_W-1:0] angle_low_r;
  logic signed [ANGLE_W-1:0] angle_high_r;
  logic                      cfg_wr;
  logic [1:0]                cfg_idx;
  cmd_t                      cmd;
  sts_t                      sts;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      travel_ms_r  <= '0;
      angle_low_r  <= '0;
      angle_high_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TRAVEL: travel_ms_r  <= cfg_pwdata[TRAVEL_W-1:0];
        REG_ANG_LO: angle_low_r  <= cfg_pwdata[ANGLE_W-1:0];
        REG_ANG_HI: angle_high_r <= cfg_pwdata[ANGLE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TRAVEL: cfg_prdata = {{(CFG_DW-TRAVEL_W){1'b0}}, travel_ms_r};
      REG_ANG_LO: cfg_prdata = {{(CFG_DW-ANGLE_W){angle_low_r[ANGLE_W-1]}}, angle_low_r};
      REG_ANG_HI: cfg_prdata = {{(CFG_DW-ANGLE_W){angle_high_r[ANGLE_W-1]}}, angle_high_r};
      default:    cfg_prdata = '0;
    endcase
  end

  mhtp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mhtp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .travel_ms  (travel_ms_r),
    .angle_low  (angle_low_r),
    .angle_high (angle_high_r),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/mhtp_checker.sv
// Port-level checks for the positioner, bound to the top level.
module mhtp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [mhtp_pkg::OUT_W-1:0] out_tdata
);
  import mhtp_pkg::*;

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // homing and move completion come from exclusive branches
  a_evt_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[4] && out_tdata[5]))
    else $error("calibration and done events in one beat");

  // calibration zeroes the position and stops the motor
  a_calib_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> (out_tdata[26:6] == '0) && !out_tdata[0])
    else $error("calibration beat with moving motor or non-zero position");

  // a finished move leaves the motor off
  a_done_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> !out_tdata[0])
    else $error("done event with motor still running");

  // already-there never starts the motor
  a_near_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:2] == STS_THERE) |-> !out_tdata[0])
    else $error("motor on after a close-enough set angle");

endmodule

bind motor_homing_timed_positioner_core mhtp_checker u_mhtp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### dv/tb_motor_homing_timed_positioner_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the timed stepper positioner core.
module tb_motor_homing_timed_positioner_core;
  import mhtp_pkg::*;

  localparam logic [1:0] ACT_SPARE   = 2'd3;   // unused action code, must be ignored
  localparam int         SETTLE_CYC  = 8;      // margin once the result stream is empty
  localparam int         DRAIN_CYC   = 60;     // quiet period before the verdict
  localparam int         STALL_LIMIT = 5000;   // cycles without any beat before giving up
  localparam int         ITEM_TARGET = 600;
  localparam int         MOVE_TICKS  = 150;    // tick cap while waiting for a move to finish

  typedef struct {
    bit          motor_on;
    bit          dir_level;
    status_t     status;
    bit          calib_ev;
    bit          done_ev;
    logic [20:0] position;
  } pos_beat_t;

  // predicts the positioner and holds the results still owed by the block
  class positioner_scoreboard;
    logic [19:0] travel;
    int          ang_lo;
    int          ang_hi;
    bit          calibrated;
    bit          move_done;
    logic [3:0]  low_cnt;
    logic [20:0] pos;
    logic [20:0] tgt;
    logic [31:0] stop_t;
    logic [31:0] now_t;
    bit          home_lvl;
    bit          motor;
    bit          dir;
    pos_beat_t   owed_q[$];
    int          errors;

    function new();
      travel = '0;
      ang_lo = 0;
      ang_hi = 0;
      calibrated = 1'b0;
      move_done = 1'b1;
      low_cnt = '0;
      pos = '0;
      tgt = '0;
      stop_t = '0;
      now_t = '0;
      home_lvl = 1'b0;
      motor = 1'b0;
      dir = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      logic signed [16:0] a17;
      a17 = val[16:0];
      case (idx)
        REG_TRAVEL: travel = val[19:0];
        REG_ANG_LO: ang_lo = int'(a17);
        REG_ANG_HI: ang_hi = int'(a17);
        default: ;
      endcase
    endfunction

    function void note_beat(logic [1:0] act, bit lim, bit hd, int ang);
      pos_beat_t       e;
      int              amin;
      int              amax;
      longint unsigned prod;
      logic [31:0]     over;
      logic [21:0]     sum;
      logic [20:0]     gap;
      e.status = STS_MOVING;
      e.calib_ev = 1'b0;
      e.done_ev = 1'b0;
      case (act)
        ACT_TICK: begin
          now_t = now_t + 32'd1;
          if (!calibrated) begin
            if (lim) low_cnt = '0;
            else if (low_cnt < LOW_SAT) low_cnt = low_cnt + 4'd1;
            if (low_cnt > LOW_LIMIT) begin
              calibrated = 1'b1;
              move_done = 1'b1;
              pos = '0;
              motor = 1'b0;
              e.calib_ev = 1'b1;
            end
          end else if (!move_done) begin
            // done on the first tick past the stop time, modulo 2^32
            over = now_t - stop_t;
            if (over != 32'd0 && !over[31]) begin
              sum = {1'b0, tgt} + over[21:0];
              if (over[31:21] != '0 || sum > {1'b0, POS_MAX}) pos = POS_MAX;
              else pos = sum[20:0];
              motor = 1'b0;
              move_done = 1'b1;
              e.done_ev = 1'b1;
            end
          end
        end
        ACT_CALIB: begin
          home_lvl = hd;
          dir = hd;
          motor = 1'b1;
        end
        ACT_ANGLE: begin
          amin = (ang_lo < ang_hi) ? ang_lo : ang_hi;
          amax = (ang_lo < ang_hi) ? ang_hi : ang_lo;
          if (travel == '0 || amin == amax) begin
            e.status = STS_FAULT;
          end else if (!calibrated || ang > amax || ang < amin) begin
            e.status = STS_REJECT;
          end else begin
            prod = 64'(travel) * 64'(ang - amin);
            prod = prod / 64'(amax - amin);
            tgt = prod[20:0];
            gap = (tgt > pos) ? tgt - pos : pos - tgt;
            move_done = 1'b0;
            if (gap < NEAR_MS) begin
              stop_t = now_t;
              motor = 1'b0;
              e.status = STS_THERE;
            end else begin
              dir = (tgt > pos) ? !home_lvl : home_lvl;
              stop_t = now_t + 32'(gap);
              motor = 1'b1;
            end
          end
        end
        default: ;
      endcase
      e.motor_on = motor;
      e.dir_level = dir;
      e.position = pos;
      owed_q.push_back(e);
    endfunction

    task report(string field, longint got, longint want);
      $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
      errors++;
    endtask

    task check_beat(logic [31:0] d);
      pos_beat_t e;
      if (owed_q.size() == 0) begin
        report("unexpected result beat", d, 0);
      end else begin
        e = owed_q.pop_front();
        if (d[0] !== e.motor_on) report("motor_on", d[0], e.motor_on);
        if (d[1] !== e.dir_level) report("dir_level", d[1], e.dir_level);
        if (d[3:2] !== e.status) report("status", d[3:2], e.status);
        if (d[4] !== e.calib_ev) report("calib_event", d[4], e.calib_ev);
        if (d[5] !== e.done_ev) report("done_event", d[5], e.done_ev);
        if (d[26:6] !== e.position) report("position_ms", d[26:6], e.position);
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;   // [0] limit_level, [1] home_dir, [18:2] target_angle
  logic [1:0]          in_tuser;   // [1:0] action
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;  // [0] motor_on, [1] dir_level, [3:2] status,
                                   // [4] calib_event, [5] done_event, [26:6] position_ms
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  positioner_scoreboard sb = new();
  bit idle_on = 1'b1;
  int beats_sent = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int cur_lo = 0;
  int cur_hi = 0;

  motor_homing_timed_positioner_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side: check each beat, stall in short random bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_beat(logic [1:0] act, bit lim, bit hd, int ang);
    logic [16:0] a17;
    a17 = 17'(ang);
    if (beats_sent > ITEM_TARGET - 120) idle_on = 1'b0;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {5'd0, a17, hd, lim};
    do @(posedge clk); while (!in_tready);
    sb.note_beat(act, lim, hd, ang);
    if (act != ACT_SPARE) beats_sent++;
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, val);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_config(logic [19:0] trav, int lo, int hi);
    cur_lo = lo;
    cur_hi = hi;
    cfg_write(REG_TRAVEL, 32'(trav));
    cfg_write(REG_ANG_LO, 32'(lo));
    cfg_write(REG_ANG_HI, 32'(hi));
  endtask

  function automatic int rand_angle();
    case ($urandom_range(0, 3))
      0: return -36000;
      1: return 36000;
      default: return int'($urandom_range(0, 72000)) - 36000;
    endcase
  endfunction

  // mostly inside the configured span, now and then anywhere
  function automatic int pick_target();
    int amin;
    int amax;
    amin = (cur_lo < cur_hi) ? cur_lo : cur_hi;
    amax = (cur_lo < cur_hi) ? cur_hi : cur_lo;
    if ($urandom_range(0, 7) == 0) return rand_angle();
    return amin + int'($urandom_range(0, amax - amin));
  endfunction

  initial begin
    logic [19:0] trav;
    int          lo;
    int          hi;
    int          n;
    int          r;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= ACT_TICK;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset config faults, spare action, homing with debounce
    send_beat(ACT_ANGLE, 1'b0, 1'b0, 0);
    send_beat(ACT_SPARE, 1'b1, 1'b1, -1);
    send_beat(ACT_TICK, 1'b1, 1'b0, 0);
    send_beat(ACT_CALIB, 1'b0, 1'b0, 0);
    wait_idle();
    set_config(20'd100, 36000, -36000);    // limits swapped on purpose
    send_beat(ACT_ANGLE, 1'b0, 1'b0, 0);    // not yet homed
    send_beat(ACT_CALIB, 1'b0, 1'b1, 0);
    repeat (4) send_beat(ACT_TICK, 1'b0, 1'b0, 0);
    send_beat(ACT_TICK, 1'b1, 1'b0, 0);     // bounce clears the count
    repeat (11) send_beat(ACT_TICK, 1'b0, 1'b0, 0);
    send_beat(ACT_ANGLE, 1'b0, 1'b0, -36000); // close enough, done next tick
    send_beat(ACT_TICK, 1'b1, 1'b1, 0);
    send_beat(ACT_ANGLE, 1'b1, 1'b0, 36000);
    send_beat(ACT_CALIB, 1'b0, 1'b0, 0);    // homing again once calibrated

    // random phases: new settings, then moves run until done or the tick cap
    while (beats_sent < ITEM_TARGET) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: trav = 20'd0;
        1: trav = 20'hF_FFFF;
        2: trav = 20'($urandom_range(1, 25));
        default: trav = 20'($urandom_range(20, 150));
      endcase
      lo = rand_angle();
      hi = ($urandom_range(0, 11) == 0) ? lo : rand_angle();
      set_config(trav, lo, hi);
      repeat ($urandom_range(2, 6)) begin
        if (beats_sent < ITEM_TARGET) begin
          send_beat(ACT_ANGLE, 1'($urandom), 1'($urandom), pick_target());
          n = 0;
          while (!sb.move_done && n < MOVE_TICKS && beats_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 59);
            if (r == 0) send_beat(ACT_CALIB, 1'($urandom), 1'($urandom), rand_angle());
            else if (r == 1) send_beat(ACT_ANGLE, 1'($urandom), 1'($urandom), pick_target());
            else if (r == 2) send_beat(ACT_SPARE, 1'($urandom), 1'($urandom), rand_angle());
            else send_beat(ACT_TICK, 1'($urandom), 1'($urandom), rand_angle());
            n++;
          end
          if ($urandom_range(0, 1) == 0) send_beat(ACT_TICK, 1'($urandom), 1'($urandom), 0);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/mhtp_pkg.sv
rtl/mhtp_ctrl.sv
rtl/mhtp_dp.sv
rtl/motor_homing_timed_positioner_core.sv
rtl/mhtp_checker.sv
dv/tb_motor_homing_timed_positioner_core.sv
